[src/lr_pkg.sv]
// shared types and constants for the line rasterizer
`timescale 1ns / 1ps

package lr_pkg;

    localparam int COORD_WIDTH = 12;
    localparam int ERR_WIDTH   = COORD_WIDTH + 3;
    localparam int INC_S_WIDTH = COORD_WIDTH + 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [COORD_WIDTH-1:0] dist_t;
    typedef logic signed [ERR_WIDTH-1:0]   err_t;
    typedef logic        [INC_S_WIDTH-1:0] inc_s_t;
    typedef logic signed [1:0]             step_t;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_code_t;

    typedef struct packed
    {
        logic   command;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
    } lr_cmd_t;

    typedef struct packed
    {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   pixel_valid;
        logic   last_pixel;
    } lr_pixel_t;

endpackage

[src/lr_cmd_if.sv]
// command channel: load or step transfers with line endpoints
`timescale 1ns / 1ps

interface lr_cmd_if
    import lr_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   command;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;

    modport source
    (
        output valid,
        output command,
        output x_start,
        output y_start,
        output x_end,
        output y_end,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  command,
        input  x_start,
        input  y_start,
        input  x_end,
        input  y_end,
        output ready
    );
endinterface

[src/lr_pix_if.sv]
// pixel channel: one result transfer per command
`timescale 1ns / 1ps

interface lr_pix_if
    import lr_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   pixel_valid;
    logic   last_pixel;

    modport source
    (
        output valid,
        output pixel_x,
        output pixel_y,
        output pixel_valid,
        output last_pixel,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  pixel_x,
        input  pixel_y,
        input  pixel_valid,
        input  last_pixel,
        output ready
    );
endinterface

[src/lr_input_stage.sv]
// input register for command transfers
`timescale 1ns / 1ps

module lr_input_stage
    import lr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    lr_cmd_if.sink  cmd,
    input  logic    advance,
    output logic    item_valid,
    output lr_cmd_t item
);

    logic    valid_reg;
    logic    valid_next;
    lr_cmd_t item_reg;
    logic    take;

    assign cmd.ready  = !valid_reg || advance;
    assign take       = cmd.valid && cmd.ready;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.command <= cmd.command;
            item_reg.x_start <= cmd.x_start;
            item_reg.y_start <= cmd.y_start;
            item_reg.x_end   <= cmd.x_end;
            item_reg.y_end   <= cmd.y_end;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[src/lr_stepper.sv]
// bresenham line state and per-command pixel computation
`timescale 1ns / 1ps

module lr_stepper
    import lr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  lr_cmd_t   item,
    output lr_pixel_t result
);

    coord_t cur_x_reg, cur_x_next;
    coord_t cur_y_reg, cur_y_next;
    coord_t major_end_reg, major_end_next;
    err_t   error_term_reg, error_term_next;
    inc_s_t inc_straight_reg, inc_straight_next;
    err_t   inc_diagonal_reg, inc_diagonal_next;
    step_t  minor_step_reg, minor_step_next;
    logic   shallow_mode_reg, shallow_mode_next;
    logic   line_active_reg, line_active_next;

    logic signed [COORD_WIDTH:0] diff_x;
    logic signed [COORD_WIDTH:0] diff_y;
    dist_t  dx;
    dist_t  dy;
    dist_t  dmaj;
    dist_t  dmin;
    logic   shallow;
    logic   swap;
    coord_t sx, sy, ex, ey;
    coord_t minor_from, minor_to;
    coord_t step_ext;
    coord_t major_new;
    logic   last;

    always_comb
    begin
        diff_x = {item.x_start[COORD_WIDTH-1], item.x_start}
               - {item.x_end[COORD_WIDTH-1], item.x_end};
        diff_y = {item.y_start[COORD_WIDTH-1], item.y_start}
               - {item.y_end[COORD_WIDTH-1], item.y_end};
        dx = diff_x[COORD_WIDTH] ? dist_t'(-diff_x) : dist_t'(diff_x);
        dy = diff_y[COORD_WIDTH] ? dist_t'(-diff_y) : dist_t'(diff_y);
        shallow = dx > dy;
        dmaj    = shallow ? dx : dy;
        dmin    = shallow ? dy : dx;
        swap    = shallow ? (item.x_start > item.x_end) : (item.y_start > item.y_end);
        sx = swap ? item.x_end   : item.x_start;
        sy = swap ? item.y_end   : item.y_start;
        ex = swap ? item.x_start : item.x_end;
        ey = swap ? item.y_start : item.y_end;
        minor_from = shallow ? sy : sx;
        minor_to   = shallow ? ey : ex;
        step_ext   = {{(COORD_WIDTH-2){minor_step_reg[1]}}, minor_step_reg};

        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        major_end_next    = major_end_reg;
        error_term_next   = error_term_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        minor_step_next   = minor_step_reg;
        shallow_mode_next = shallow_mode_reg;
        line_active_next  = line_active_reg;
        major_new         = '0;
        last              = 1'b0;
        result            = '0;

        if (item.command == CMD_LOAD)
        begin
            cur_x_next        = sx;
            cur_y_next        = sy;
            shallow_mode_next = shallow;
            major_end_next    = shallow ? ex : ey;
            if (minor_to > minor_from)
            begin
                minor_step_next = 2'sb01;
            end
            else if (minor_to < minor_from)
            begin
                minor_step_next = 2'sb11;
            end
            else
            begin
                minor_step_next = 2'sb00;
            end
            error_term_next   = err_t'({2'b00, dmin, 1'b0}) - err_t'({3'b000, dmaj});
            inc_straight_next = {1'b0, dmin, 1'b0};
            inc_diagonal_next = err_t'({2'b00, dmin, 1'b0}) - err_t'({2'b00, dmaj, 1'b0});
            last              = shallow ? (sx == ex) : (sy == ey);
            line_active_next  = !last;
            result.pixel_x     = sx;
            result.pixel_y     = sy;
            result.pixel_valid = 1'b1;
            result.last_pixel  = last;
        end
        else if (line_active_reg)
        begin
            if (shallow_mode_reg)
            begin
                cur_x_next = cur_x_reg + coord_t'(1);
            end
            else
            begin
                cur_y_next = cur_y_reg + coord_t'(1);
            end
            if (error_term_reg < 0)
            begin
                error_term_next = error_term_reg + err_t'({1'b0, inc_straight_reg});
            end
            else
            begin
                if (shallow_mode_reg)
                begin
                    cur_y_next = cur_y_reg + step_ext;
                end
                else
                begin
                    cur_x_next = cur_x_reg + step_ext;
                end
                error_term_next = error_term_reg + inc_diagonal_reg;
            end
            major_new        = shallow_mode_reg ? cur_x_next : cur_y_next;
            last             = major_new == major_end_reg;
            line_active_next = !last;
            result.pixel_x     = cur_x_next;
            result.pixel_y     = cur_y_next;
            result.pixel_valid = 1'b1;
            result.last_pixel  = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
        end
        else if (advance)
        begin
            line_active_reg <= line_active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            major_end_reg    <= major_end_next;
            error_term_reg   <= error_term_next;
            inc_straight_reg <= inc_straight_next;
            inc_diagonal_reg <= inc_diagonal_next;
            minor_step_reg   <= minor_step_next;
            shallow_mode_reg <= shallow_mode_next;
        end
    end

endmodule

[src/lr_output_stage.sv]
// result register driving the pixel channel
`timescale 1ns / 1ps

module lr_output_stage
    import lr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  lr_pixel_t result,
    output logic      free,
    lr_pix_if.source  pix
);

    logic      valid_reg;
    logic      valid_next;
    lr_pixel_t result_reg;

    assign free       = !valid_reg || pix.ready;
    assign valid_next = load || (valid_reg && !pix.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign pix.valid       = valid_reg;
    assign pix.pixel_x     = result_reg.pixel_x;
    assign pix.pixel_y     = result_reg.pixel_y;
    assign pix.pixel_valid = result_reg.pixel_valid;
    assign pix.last_pixel  = result_reg.last_pixel;

endmodule

[src/line_rasterizer.sv]
// top level of the bresenham line rasterizer
`timescale 1ns / 1ps

// Every command transfer yields exactly one pixel transfer, in order. A load
// returns the first pixel of the new line; each step returns the next pixel,
// or a pixel with pixel_valid low once the line is finished. The block takes
// one command per clock and returns one pixel per clock when the pixel side
// keeps ready high; a command is captured in the input register and then
// moves into the result register, which drives pixel valid. The rate is set
// by the step: one add on the error term and one compare against the line's
// end, between the input and result registers.

module line_rasterizer
    import lr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    lr_cmd_if.sink   cmd,
    lr_pix_if.source pixel
);

    logic      item_valid;
    lr_cmd_t   item;
    lr_pixel_t result;
    logic      out_free;
    logic      advance;

    assign advance = item_valid && out_free;

    lr_input_stage u_input
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lr_stepper u_stepper
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    lr_output_stage u_output
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (result),
        .free   (out_free),
        .pix    (pixel)
    );

    // finished line returns an all-zero pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && !pixel.pixel_valid) |->
            (pixel.pixel_x == '0 && pixel.pixel_y == '0 && !pixel.last_pixel))
        else $error("invalid pixel carries nonzero fields");

    // every processed command shows up as a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> pixel.valid)
        else $error("processed command produced no result");

    // a held command keeps its payload until processed
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !advance) |=> (item_valid && $stable(item)))
        else $error("held command lost or changed");

endmodule

[test/tb_line_rasterizer.sv]
// self-checking testbench for the bresenham line rasterizer
`timescale 1ns / 1ps

module tb_line_rasterizer;
    import lr_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int C_MIN        = -(2 ** (COORD_WIDTH - 1));
    localparam int C_MAX        = 2 ** (COORD_WIDTH - 1) - 1;

    logic clk;
    logic rst_n;

    lr_cmd_if cmd_if();
    lr_pix_if pix_if();

    line_rasterizer dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .pixel (pix_if)
    );

    lr_cmd_t   cmd_queue[$];
    lr_pixel_t pixel_queue[$];
    int        directed_cnt;
    int        cmd_total;
    int        cmd_sent;
    int        pixel_seen;
    int        err_cnt;
    int        hold_left;
    bit        hold_done;

    // line walker state
    int pen_x;
    int pen_y;
    int stop_major;
    int decision;
    int add_flat;
    int add_diag;
    int minor_dir;
    bit x_major;
    bit drawing;

    function automatic lr_pixel_t draw_pixel(lr_cmd_t c);
        lr_pixel_t px;
        int        ax;
        int        ay;
        int        bx;
        int        by;
        int        dx;
        int        dy;
        int        d_major;
        int        d_minor;
        int        diff;
        int        t;
        bit        at_end;
        px = '0;
        if (c.command == CMD_LOAD)
        begin
            ax = c.x_start;
            ay = c.y_start;
            bx = c.x_end;
            by = c.y_end;
            dx = (ax > bx) ? ax - bx : bx - ax;
            dy = (ay > by) ? ay - by : by - ay;
            x_major = dx > dy;
            d_major = x_major ? dx : dy;
            d_minor = x_major ? dy : dx;
            if (x_major ? (ax > bx) : (ay > by))
            begin
                t  = ax;
                ax = bx;
                bx = t;
                t  = ay;
                ay = by;
                by = t;
            end
            pen_x      = ax;
            pen_y      = ay;
            stop_major = x_major ? bx : by;
            diff       = x_major ? by - ay : bx - ax;
            minor_dir  = (diff > 0) ? 1 : ((diff < 0) ? -1 : 0);
            decision   = 2 * d_minor - d_major;
            add_flat   = 2 * d_minor;
            add_diag   = 2 * (d_minor - d_major);
            at_end     = (x_major ? pen_x : pen_y) == stop_major;
            drawing    = !at_end;
        end
        else if (!drawing)
        begin
            return px;
        end
        else
        begin
            if (x_major)
                pen_x += 1;
            else
                pen_y += 1;
            if (decision < 0)
                decision += add_flat;
            else
            begin
                if (x_major)
                    pen_y += minor_dir;
                else
                    pen_x += minor_dir;
                decision += add_diag;
            end
            at_end = (x_major ? pen_x : pen_y) == stop_major;
            if (at_end)
                drawing = 1'b0;
        end
        px.pixel_x     = coord_t'(pen_x);
        px.pixel_y     = coord_t'(pen_y);
        px.pixel_valid = 1'b1;
        px.last_pixel  = at_end;
        return px;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(7))
            0:       return C_MIN;
            1:       return C_MAX;
            default: return int'($urandom_range(C_MAX - C_MIN)) + C_MIN;
        endcase
    endfunction

    function automatic void push_cmd(cmd_code_t op, int xs, int ys, int xe, int ye);
        lr_cmd_t c;
        c.command = op;
        c.x_start = coord_t'(xs);
        c.y_start = coord_t'(ys);
        c.x_end   = coord_t'(xe);
        c.y_end   = coord_t'(ye);
        cmd_queue.push_back(c);
    endfunction

    // step fields carry random values, the block must ignore them
    function automatic void push_step();
        push_cmd(CMD_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endfunction

    // load a line near a random point, walk it, sometimes cut short or past the end
    function automatic void push_line(int reach);
        int x0;
        int y0;
        int x1;
        int y1;
        int dx;
        int dy;
        int steps;
        x0 = rand_coord();
        y0 = rand_coord();
        x1 = x0 + int'($urandom_range(2 * reach)) - reach;
        y1 = y0 + int'($urandom_range(2 * reach)) - reach;
        if (x1 > C_MAX || x1 < C_MIN)
            x1 = 2 * x0 - x1;
        if (y1 > C_MAX || y1 < C_MIN)
            y1 = 2 * y0 - y1;
        if ($urandom_range(9) == 0)
            y1 = (y0 + (x1 - x0) <= C_MAX && y0 + (x1 - x0) >= C_MIN) ? y0 + (x1 - x0)
                                                                      : y0 - (x1 - x0);
        if ($urandom_range(1) == 0)
            push_cmd(CMD_LOAD, x0, y0, x1, y1);
        else
            push_cmd(CMD_LOAD, x1, y1, x0, y0);
        dx    = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy    = (y1 > y0) ? y1 - y0 : y0 - y1;
        steps = ((dx > dy) ? dx : dy) + int'($urandom_range(2));
        if ($urandom_range(4) == 0)
            steps = $urandom_range((dx > dy) ? dx : dy);
        repeat (steps)
            push_step();
    endfunction

    function automatic int idle_pct(bit sender);
        if (cmd_sent < cmd_total / 3)
            return sender ? 28 : 79;
        if (cmd_sent < 2 * cmd_total / 3)
            return sender ? 79 : 28;
        return 0;
    endfunction

    task automatic check_field(string field, coord_t want, coord_t got);
        if (got !== want)
        begin
            err_cnt++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        lr_cmd_t next_cmd;
        if (!rst_n)
        begin
            cmd_if.valid   <= 1'b0;
            cmd_if.command <= CMD_LOAD;
            cmd_if.x_start <= '0;
            cmd_if.y_start <= '0;
            cmd_if.x_end   <= '0;
            cmd_if.y_end   <= '0;
            cmd_sent       <= 0;
        end
        else
        begin
            if (cmd_if.valid && cmd_if.ready)
            begin
                pixel_queue.push_back(draw_pixel(lr_cmd_t'({cmd_if.command, cmd_if.x_start,
                    cmd_if.y_start, cmd_if.x_end, cmd_if.y_end})));
                cmd_sent <= cmd_sent + 1;
            end
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b1))
                begin
                    next_cmd = cmd_queue.pop_front();
                    cmd_if.valid   <= 1'b1;
                    cmd_if.command <= next_cmd.command;
                    cmd_if.x_start <= next_cmd.x_start;
                    cmd_if.y_start <= next_cmd.y_start;
                    cmd_if.x_end   <= next_cmd.x_end;
                    cmd_if.y_end   <= next_cmd.y_end;
                end
                else
                    cmd_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : pixel_monitor
        lr_pixel_t want;
        if (!rst_n)
        begin
            pix_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
            pixel_seen   <= 0;
        end
        else
        begin
            if (pix_if.valid && pix_if.ready)
            begin
                pixel_seen <= pixel_seen + 1;
                if (pixel_queue.size() == 0)
                begin
                    err_cnt++;
                    $error("pixel transfer with no command waiting");
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    check_field("pixel_x", want.pixel_x, pix_if.pixel_x);
                    check_field("pixel_y", want.pixel_y, pix_if.pixel_y);
                    check_field("pixel_valid", coord_t'(want.pixel_valid),
                                coord_t'(pix_if.pixel_valid));
                    check_field("last_pixel", coord_t'(want.last_pixel),
                                coord_t'(pix_if.last_pixel));
                end
            end
            // long back-pressure once, so the block fills and stalls commands
            if (hold_left > 0)
            begin
                pix_if.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end
            else if (!hold_done && pixel_seen >= 100)
            begin
                pix_if.ready <= 1'b0;
                hold_left    <= 80;
                hold_done    <= 1'b1;
            end
            else
                pix_if.ready <= $urandom_range(99) >= idle_pct(1'b0);
        end
    end

    initial
    begin
        rst_n = 1'b0;

        // step with no line, single-pixel line, corner to corner and edge to edge lines
        push_step();
        push_cmd(CMD_LOAD, C_MAX, C_MIN, C_MAX, C_MIN);
        push_step();
        push_cmd(CMD_LOAD, C_MIN, C_MIN, C_MAX, C_MAX);
        push_step();
        push_step();
        push_cmd(CMD_LOAD, C_MAX, C_MIN, C_MIN, C_MAX);
        push_step();
        push_cmd(CMD_LOAD, C_MAX, 0, C_MIN, 5);
        push_step();
        push_cmd(CMD_LOAD, 0, C_MAX, 0, C_MIN);
        push_step();
        // short lines walked past their end
        push_cmd(CMD_LOAD, 0, 0, 3, 1);
        repeat (4)
            push_step();
        push_cmd(CMD_LOAD, 0, 0, -1, -3);
        repeat (4)
            push_step();
        directed_cnt = cmd_queue.size();

        while (cmd_queue.size() < directed_cnt + RANDOM_ITEMS)
        begin
            if ($urandom_range(9) == 0)
                push_cmd(cmd_code_t'($urandom_range(1)), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord());
            else if ($urandom_range(39) == 0)
                push_line(300);
            else
                push_line($urandom_range(1, 12));
        end
        cmd_total = cmd_queue.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || cmd_if.valid || pixel_queue.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
